### hdl/wptd_pkg.sv
// Package: shared types, codes and constants of the token dispatcher.
package wptd_pkg;

  localparam int unsigned NumQueuesDef   = 4;
  localparam int unsigned QueueDepthDef  = 256;
  localparam int unsigned FlowIdBitsDef  = 16;
  localparam int unsigned NumWeightRegs  = 4;
  localparam int unsigned PercentDiv     = 100;
  // floor(x / 100) == (x * WmRecip) >> WmShift for every x below 2**23
  localparam logic [23:0] WmRecip        = 24'd10737419;
  localparam int unsigned WmShift        = 30;
  localparam logic [15:0] TokenLimitRst  = 16'd1024;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_RET  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DISP = 2'd1,
    KIND_SUM  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_ACTIVE  = 3'd0,
    REG_W0      = 3'd1,
    REG_W1      = 3'd2,
    REG_W2      = 3'd3,
    REG_W3      = 3'd4,
    REG_LIMIT   = 3'd5,
    REG_PERCENT = 3'd6,
    REG_GAP     = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WMARK,
    ST_SELECT,
    ST_READ,
    ST_EMIT,
    ST_SUMMARY
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] flow_id;
    logic [1:0]  prio;
    logic [63:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_flow;
    logic [1:0]  out_prio;
    logic        dropped;
    logic        congestion_event;
    logic [15:0] occupied;
    logic [5:0]  dispatched_count;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  active_queues;
    logic [15:0] weights;
    logic [15:0] token_limit;
    logic [6:0]  watermark_percent;
    logic [31:0] pass_gap;
  } cfg_t;

endpackage

### hdl/weighted_priority_token_dispatcher.sv
// Top level: weighted strict-priority dispatcher with a token pool.
//
// channel | signals                      | word
// in      | in_valid_i / in_ready_o      | in_word_t  (op, flow_id, prio, now_time)
// out     | out_valid_o / out_ready_i    | out_word_t (one result per word)
// cfg     | cfg_we_i, cfg_idx_i, cfg_data_i | register write, no wait
//
// Enqueue: word in the output register the cycle after it is accepted.
// Return token and early tick: no word.
// Pass: the tick cycle latches limit*percent, the WMARK state scales it to the watermark;
// then each dispatch runs select, memory read and emit, the read state being needed by the
// registered read port of the flow memory, a select step for each queue left, summary last.
// Stalls: a held output word blocks in_ready_o and holds the FSM in its emit states.
// Reset: pointers, counters and flags to zero, tokens 1024, registers to defaults.
module weighted_priority_token_dispatcher #(
  parameter int unsigned NUM_QUEUES   = wptd_pkg::NumQueuesDef,
  parameter int unsigned QUEUE_DEPTH  = wptd_pkg::QueueDepthDef,
  parameter int unsigned FLOW_ID_BITS = wptd_pkg::FlowIdBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wptd_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wptd_pkg::out_word_t  out_word_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);
  import wptd_pkg::*;

  localparam int unsigned QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW  = PW + 1;
  localparam int unsigned AW  = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int unsigned NQW = $clog2(NUM_QUEUES + 1);

  cfg_t cfg_q;

  logic [PW-1:0] head_q [NUM_QUEUES];
  logic [PW-1:0] tail_q [NUM_QUEUES];
  logic [FW-1:0] fill_q [NUM_QUEUES];
  logic [15:0]   tokens_q;
  logic          cong_q;
  logic [63:0]   last_time_q;

  state_e        state_q, state_d;
  logic [3:0]    qcur_q;          // queue index + 1 of the queue in service
  logic [3:0]    wleft_q;
  logic [5:0]    count_q;
  logic [63:0]   now_q;
  logic [16:0]   wmark_q;         // up to 65535 * 127 / 100
  logic [22:0]   prod_q;

  out_word_t     out_q;
  logic          out_valid_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_rdata;

  // flow id masked to the parameter width
  logic [15:0]   flow_m;
  logic [QW-1:0] qi;
  logic          can_emit;

  always_comb begin
    flow_m = 16'(in_word_i.flow_id & 16'(((33'd1 << FLOW_ID_BITS) - 33'd1)));
    qi     = QW'(qcur_q - 4'd1);
  end

  function automatic logic [15:0] occ_f(logic [15:0] lim, logic [15:0] tok);
    return (tok > lim) ? 16'd0 : 16'(lim - tok);
  endfunction

  function automatic logic [3:0] weight_f(cfg_t c, logic [3:0] q);
    logic [3:0] w;
    w = 4'd0;
    if (q < 4'(NumWeightRegs)) begin
      w = c.weights[q[1:0]*4 +: 4];
    end
    return w;
  endfunction

  assign can_emit   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && can_emit;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  wptd_store #(
    .Depth (NUM_QUEUES * QUEUE_DEPTH),
    .Width (16)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (flow_m),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  logic acc;
  logic enq_ok;
  logic emit_now;
  logic [NQW-1:0] nq;
  assign acc = in_valid_i && in_ready_o;
  assign nq  = (32'(cfg_q.active_queues) > NUM_QUEUES) ? NQW'(NUM_QUEUES)
                                                     : NQW'(cfg_q.active_queues);
  // a new word enters the output register at this edge
  assign emit_now = (acc && (in_word_i.op == OP_ENQ)) ||
                    (((state_q == ST_EMIT) || (state_q == ST_SUMMARY)) && can_emit);

  always_comb begin
    enq_ok    = (32'(in_word_i.prio) < NUM_QUEUES) &&
                (fill_q[QW'(in_word_i.prio)] < FW'(QUEUE_DEPTH));
    mem_we    = acc && (in_word_i.op == OP_ENQ) && enq_ok;
    mem_waddr = AW'({in_word_i.prio, {PW{1'b0}}}) + AW'(tail_q[QW'(in_word_i.prio)]);
    if (NUM_QUEUES > 1) mem_waddr = AW'(({{(AW){1'b0}}, in_word_i.prio} << PW))
                                    + AW'(tail_q[QW'(in_word_i.prio)]);
    mem_raddr = AW'((AW'(qi) << PW)) + AW'(head_q[qi]);
  end

  // next state
  logic serve_ok;
  assign serve_ok = (qcur_q != 4'd0) && (wleft_q != 4'd0) && (tokens_q != 16'd0) &&
                    (fill_q[qi] != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && (in_word_i.op == OP_TICK) &&
            (64'(in_word_i.now_time - last_time_q) > 64'(cfg_q.pass_gap))) begin
          state_d = ST_WMARK;
        end
      end
      ST_WMARK:   state_d = ST_SELECT;
      ST_SELECT: begin
        if (qcur_q == 4'd0)     state_d = ST_SUMMARY;
        else if (serve_ok)      state_d = ST_READ;
      end
      ST_READ:    state_d = ST_EMIT;
      ST_EMIT:    if (can_emit) state_d = ST_SELECT;
      ST_SUMMARY: if (can_emit) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  logic [15:0] tok_dec, occ_dec;
  logic        over_mark;
  assign tok_dec   = tokens_q - 16'd1;
  assign occ_dec   = occ_f(cfg_q.token_limit, tok_dec);
  assign over_mark = ({1'b0, occ_dec} >= wmark_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= '{active_queues: 3'd4, weights: 16'h1111,
                       token_limit: TokenLimitRst, watermark_percent: 7'd80,
                       pass_gap: 32'd1000};
      tokens_q    <= TokenLimitRst;
      cong_q      <= 1'b0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
      qcur_q      <= '0;
      wleft_q     <= '0;
      count_q     <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= emit_now || (out_valid_q && !out_ready_i);

      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_ACTIVE:  cfg_q.active_queues <= cfg_data_i[2:0];
          REG_W0:      cfg_q.weights[3:0]   <= cfg_data_i[3:0];
          REG_W1:      cfg_q.weights[7:4]   <= cfg_data_i[3:0];
          REG_W2:      cfg_q.weights[11:8]  <= cfg_data_i[3:0];
          REG_W3:      cfg_q.weights[15:12] <= cfg_data_i[3:0];
          REG_LIMIT: begin
            cfg_q.token_limit <= cfg_data_i[15:0];
            tokens_q          <= cfg_data_i[15:0];
          end
          REG_PERCENT: cfg_q.watermark_percent <= cfg_data_i[6:0];
          REG_GAP:     cfg_q.pass_gap <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            case (in_word_i.op)
              OP_ENQ: begin
                if (enq_ok) begin
                  tail_q[QW'(in_word_i.prio)] <= PW'(tail_q[QW'(in_word_i.prio)] + 1'b1);
                  fill_q[QW'(in_word_i.prio)] <= fill_q[QW'(in_word_i.prio)] + 1'b1;
                end
                out_q <= '{kind: KIND_ENQ, out_flow: flow_m, out_prio: in_word_i.prio,
                           dropped: !enq_ok, congestion_event: 1'b0,
                           occupied: occ_f(cfg_q.token_limit, tokens_q),
                           dispatched_count: 6'd0, last: 1'b1};
              end
              OP_RET: begin
                if (tokens_q < cfg_q.token_limit) tokens_q <= tokens_q + 16'd1;
                else tokens_q <= cfg_q.token_limit;
              end
              default: ;
            endcase
            if (state_d == ST_WMARK) begin
              now_q   <= in_word_i.now_time;
              prod_q  <= 23'(cfg_q.token_limit) * 23'(cfg_q.watermark_percent);
              qcur_q  <= 4'(nq);
              wleft_q <= weight_f(cfg_q, 4'(nq) - 4'd1);
              count_q <= '0;
            end
          end
        end
        // divide by 100 through a reciprocal multiply
        ST_WMARK: wmark_q <= 17'((47'(prod_q) * 47'(WmRecip)) >> WmShift);
        ST_SELECT: begin
          if ((qcur_q != 4'd0) && !serve_ok) begin
            qcur_q  <= qcur_q - 4'd1;
            wleft_q <= weight_f(cfg_q, qcur_q - 4'd2);
          end
        end
        ST_READ: ;
        ST_EMIT: begin
          if (can_emit) begin
            head_q[qi]  <= PW'(head_q[qi] + 1'b1);
            fill_q[qi]  <= fill_q[qi] - 1'b1;
            tokens_q    <= tok_dec;
            wleft_q     <= wleft_q - 4'd1;
            count_q     <= count_q + 6'd1;
            out_q <= '{kind: KIND_DISP, out_flow: mem_rdata, out_prio: 2'(qi),
                       dropped: 1'b0,
                       congestion_event: (cfg_q.token_limit != 0) && over_mark && !cong_q,
                       occupied: occ_dec, dispatched_count: 6'd0, last: 1'b0};
            if (cfg_q.token_limit != 0) cong_q <= over_mark;
          end
        end
        ST_SUMMARY: begin
          if (can_emit) begin
            last_time_q <= now_q;
            out_q <= '{kind: KIND_SUM, out_flow: 16'd0, out_prio: 2'd0, dropped: 1'b0,
                       congestion_event: 1'b0,
                       occupied: occ_f(cfg_q.token_limit, tokens_q),
                       dispatched_count: count_q, last: 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o) else $error("accept during pass");
  a_tokens_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && can_emit && !cfg_we_i) |=> (tokens_q == $past(tokens_q) - 16'd1))
    else $error("dispatch did not take a token");
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.kind == KIND_SUM) |-> out_word_o.last)
    else $error("summary not marked last");
`endif
endmodule

### hdl/wptd_store.sv
// Flow id memory: one write port, one registered read port.
module wptd_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
